>>> design/rsc_pkg.sv
// Shared constants, codes and controller/datapath signal groups for the rotation checker.
`default_nettype none

package rsc_pkg;

    // Default store depth
    localparam int DEFAULT_MAX_LEN = 64;

    // Payload widths
    localparam int KIND_W   = 2;
    localparam int SYM_W    = 8;
    localparam int STATUS_W = 2;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DIFF  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_LONG  = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic load_first;   // store symbol into first string
        logic load_second;  // store symbol into second string
        logic start;        // check beat taken: latch status, clear lengths
        logic advance;      // compare cycle: step the rotation counters
        logic wr_result;    // load the result register
        logic result_rot;   // rotation verdict for wr_result
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [STATUS_W-1:0] pre_status;  // status the check would report now
        logic                sym_match;   // registered symbols are equal
        logic                inner_last;  // last symbol of this rotation
        logic                shift_last;  // last rotation
    } dp_sts_t;

endpackage

`default_nettype wire

>>> design/rsc_if.sv
// Handshake channel interfaces for the input items and the results.
`default_nettype none

interface rsc_in_if
    import rsc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol;

    modport source (output valid, output kind, output symbol, input ready);
    modport sink   (input valid, input kind, input symbol, output ready);
endinterface

interface rsc_out_if
    import rsc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                is_rotation;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output is_rotation, output status, input ready);
    modport sink   (input valid, input is_rotation, input status, output ready);
endinterface

`default_nettype wire

>>> design/rsc_datapath.sv
// Datapath: string stores, lengths, overflow flag, rotation counters and result register.
`default_nettype none

module rsc_datapath
    import rsc_pkg::*;
#(
    parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dp_cmd_t             cmd,
    input  wire logic [SYM_W-1:0]    symbol,
    output dp_sts_t                  sts,
    output logic                     is_rotation,
    output logic [STATUS_W-1:0]      status
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam logic [LW-1:0] FULL = LW'(MAX_LEN);

    // Stores
    logic [SYM_W-1:0] first_mem  [MAX_LEN];
    logic [SYM_W-1:0] second_mem [MAX_LEN];

    logic [LW-1:0]       first_len_reg, first_len_next;
    logic [LW-1:0]       second_len_reg, second_len_next;
    logic                overflow_reg, overflow_next;
    logic [AW-1:0]       nm1_reg;
    logic [AW-1:0]       shift_reg, i_reg, j_reg;
    logic [SYM_W-1:0]    rd_first_reg, rd_second_reg;
    logic [STATUS_W-1:0] chk_status_reg;
    logic                is_rotation_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] pre_status;

    logic first_full, second_full;

    assign first_full  = (first_len_reg == FULL);
    assign second_full = (second_len_reg == FULL);

    // Status the check would give from the current lengths
    always_comb
    begin
        if (overflow_reg)
            pre_status = STATUS_LONG;
        else if (first_len_reg == '0 || second_len_reg == '0)
            pre_status = STATUS_EMPTY;
        else if (first_len_reg != second_len_reg)
            pre_status = STATUS_DIFF;
        else
            pre_status = STATUS_OK;
    end

    assign sts = '{pre_status: pre_status,
                   sym_match:  (rd_first_reg == rd_second_reg),
                   inner_last: (i_reg == nm1_reg),
                   shift_last: (shift_reg == nm1_reg)};

    // Length and overflow bookkeeping
    always_comb
    begin
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        overflow_next   = overflow_reg;
        if (cmd.start)
        begin
            first_len_next  = '0;
            second_len_next = '0;
            overflow_next   = 1'b0;
        end
        else if (cmd.load_first)
        begin
            if (first_full)
                overflow_next = 1'b1;
            else
                first_len_next = first_len_reg + LW'(1);
        end
        else if (cmd.load_second)
        begin
            if (second_full)
                overflow_next = 1'b1;
            else
                second_len_next = second_len_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            overflow_reg   <= overflow_next;
        end
    end

    // Store writes and registered reads, one port each
    always_ff @(posedge clk)
    begin
        if (cmd.load_first && !first_full)
            first_mem[first_len_reg[AW-1:0]] <= symbol;
        rd_first_reg <= first_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_second && !second_full)
            second_mem[second_len_reg[AW-1:0]] <= symbol;
        rd_second_reg <= second_mem[i_reg];
    end

    // Rotation counters: shift = rotation, i = second index, j = first index
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            nm1_reg        <= AW'(first_len_reg - LW'(1));
            shift_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            chk_status_reg <= pre_status;
        end
        else if (cmd.advance)
        begin
            if (sts.sym_match)
            begin
                i_reg <= i_reg + AW'(1);
                j_reg <= (j_reg == nm1_reg) ? '0 : j_reg + AW'(1);
            end
            else
            begin
                shift_reg <= shift_reg + AW'(1);
                i_reg     <= '0;
                j_reg     <= shift_reg + AW'(1);
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.wr_result)
        begin
            is_rotation_reg <= cmd.result_rot;
            status_reg      <= chk_status_reg;
        end
    end

    assign is_rotation = is_rotation_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire

>>> design/rsc_ctrl.sv
// Controller: takes items, sequences the rotation walk and owns the result valid.
`default_nettype none

module rsc_ctrl
    import rsc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [KIND_W-1:0] in_kind,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire dp_sts_t           sts,
    output dp_cmd_t                cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   rot_reg, rot_next;
    logic   out_valid_reg, out_valid_next;
    logic   take;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign take      = in_valid && in_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        rot_next       = rot_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.result_rot = rot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    unique case (in_kind)
                        KIND_FIRST:  cmd.load_first  = 1'b1;
                        KIND_SECOND: cmd.load_second = 1'b1;
                        KIND_CHECK:
                        begin
                            cmd.start = 1'b1;
                            rot_next  = 1'b0;
                            state_next = (sts.pre_status == STATUS_OK) ? ST_READ : ST_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
                state_next = ST_CMP;
            ST_CMP:
            begin
                cmd.advance = 1'b1;
                if (sts.sym_match && sts.inner_last)
                begin
                    rot_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!sts.sym_match && sts.shift_last)
                begin
                    rot_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_READ;
            end
            ST_DONE:
            begin
                // wait for the result slot to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.wr_result  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rot_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rot_reg       <= rot_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> design/string_rotation_check.sv
// Top level of the string rotation checker: controller, datapath and assertions.
//
// Items load symbols of a first string (kind 0) or a second string (kind 1), one per
// cycle while no check runs, up to MAX_LEN each; extra symbols are dropped and flag
// overflow. A kind 2 beat runs the check, clears both lengths and gives one result:
// status 0 with the rotation verdict, or status 1 (empty), 2 (lengths differ), 3 (too
// long) with is_rotation 0. Kind 3 beats are absorbed. A load is taken even while a
// result waits. A check that fails on status skips the compare and goes straight to
// the result. A full compare walks the rotations in turn until one matches, with one
// read per store per symbol pair; each pair is a registered memory read, then a
// compare, through the single read port of each store. Input ready is low while a
// check runs. The stores need no clearing after reset.
`default_nettype none

module string_rotation_check
    import rsc_pkg::*;
#(
    parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rsc_in_if.sink     item,
    rsc_out_if.source  result
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    rsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_kind   (item.kind),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rsc_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .symbol      (item.symbol),
        .sts         (sts),
        .is_rotation (result.is_rotation),
        .status      (result.status)
    );

    // A failed status never reports a rotation
    a_status_rot: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.status == STATUS_OK || !result.is_rotation))
        else $error("rotation reported with non-compare status");

    // A check beat makes the block busy
    a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.kind == KIND_CHECK) |=> !item.ready)
        else $error("input still ready after a check beat");

    // A new result only appears at the end of a check
    a_result_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(!item.ready))
        else $error("result raised outside a check");

    // Never write a result while loads are being taken
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_result |-> !item.ready)
        else $error("result written while idle");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the string rotation checker: stimulus, scoreboard, watchdog.
`default_nettype none

module tb
    import rsc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = DEFAULT_MAX_LEN;
    localparam int IDLE_LIMIT   = 40000;   // well above the longest full compare
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BEATS = 320;
    localparam int MAX_REPORTS  = 10;

    // kind code the block absorbs without effect
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic                is_rotation;
        logic [STATUS_W-1:0] status;
    } verdict_t;

    typedef logic [SYM_W-1:0] sym_q_t [$];

    logic clk;
    logic rst_n;

    rsc_in_if  in_ch ();
    rsc_out_if out_ch ();

    string_rotation_check #(
        .MAX_LEN(DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch)
    );

    // shadow copy of the two strings
    logic [SYM_W-1:0] first_sym  [DEPTH];
    logic [SYM_W-1:0] second_sym [DEPTH];
    int               first_len;
    int               second_len;
    bit               too_long;

    verdict_t verdict_q [$];

    int mismatches;
    int beats_sent;
    int absorbed_beats;
    int status_seen [4];
    int rotations_seen;
    int burst_left;
    bit sender_bursty;
    bit recv_random;
    bit hold_req;
    int idle_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // does the second string occur in the first one doubled
    function automatic bit second_rotates_first(input int n);
        bit same;
        for (int shift = 0; shift < n; shift++)
        begin
            same = 1'b1;
            for (int i = 0; i < n; i++)
                if (second_sym[i] !== first_sym[(shift + i) % n])
                    same = 1'b0;
            if (same)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // apply one accepted beat to the shadow state, queue the verdict on a check
    function automatic void track_beat(input logic [KIND_W-1:0] kind,
                                       input logic [SYM_W-1:0] sym);
        verdict_t v;
        case (kind)
            KIND_FIRST:
                if (first_len < DEPTH)
                begin
                    first_sym[first_len] = sym;
                    first_len++;
                end
                else
                    too_long = 1'b1;
            KIND_SECOND:
                if (second_len < DEPTH)
                begin
                    second_sym[second_len] = sym;
                    second_len++;
                end
                else
                    too_long = 1'b1;
            KIND_CHECK:
            begin
                v.is_rotation = 1'b0;
                if (too_long)
                    v.status = STATUS_LONG;
                else if (first_len == 0 || second_len == 0)
                    v.status = STATUS_EMPTY;
                else if (first_len != second_len)
                    v.status = STATUS_DIFF;
                else
                begin
                    v.status      = STATUS_OK;
                    v.is_rotation = second_rotates_first(first_len);
                end
                verdict_q.push_back(v);
                first_len  = 0;
                second_len = 0;
                too_long   = 1'b0;
            end
            default:
                absorbed_beats++;
        endcase
    endfunction

    // drive one beat, with random gaps between bursts when the sender is bursty
    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym);
        int gap;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = sender_bursty ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_ch.valid  <= 1'b1;
        in_ch.kind   <= kind;
        in_ch.symbol <= sym;
        do
            @(posedge clk);
        while (!in_ch.ready);
        track_beat(kind, sym);
        burst_left--;
        if (kind != KIND_NONE)
            beats_sent++;
    endtask

    // load both strings in random interleaving, with the odd ignored beat, then check
    task automatic send_strings(input sym_q_t a, input sym_q_t b);
        int ia;
        int ib;
        ia = 0;
        ib = 0;
        while (ia < a.size() || ib < b.size())
        begin
            if ($urandom_range(0, 15) == 0)
                send_beat(KIND_NONE, SYM_W'($urandom));
            if (ib >= b.size() || (ia < a.size() && $urandom_range(0, 1)))
            begin
                send_beat(KIND_FIRST, a[ia]);
                ia++;
            end
            else
            begin
                send_beat(KIND_SECOND, b[ib]);
                ib++;
            end
        end
        send_beat(KIND_CHECK, SYM_W'($urandom));
    endtask

    // one random case: mostly rotations and near misses, some broken sequences
    task automatic random_case();
        sym_q_t           a;
        sym_q_t           b;
        int               n;
        int               sel;
        int               k;
        int               j;
        int               target;
        bit               narrow;
        logic [SYM_W-1:0] base;
        sel = $urandom_range(0, 99);
        if (sel < 90)
            n = $urandom_range(1, 8);
        else if (sel < 97)
            n = $urandom_range(9, 24);
        else
            n = $urandom_range(25, DEPTH);
        // a two-symbol alphabet makes partial matches common
        narrow = $urandom_range(0, 1);
        base   = SYM_W'($urandom);
        for (int i = 0; i < n; i++)
            a.push_back(SYM_W'(narrow ? base + $urandom_range(0, 1) : $urandom));
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
            b.push_back(a[(i + k) % n]);
        sel = $urandom_range(0, 99);
        if (sel < 45)
            ;
        else if (sel < 70)
        begin
            j = $urandom_range(0, n - 1);
            b[j] = b[j] ^ (8'h01 << $urandom_range(0, 7));
        end
        else if (sel < 80)
        begin
            for (int i = 0; i < n; i++)
                b[i] = SYM_W'(narrow ? base + $urandom_range(0, 1) : $urandom);
        end
        else if (sel < 88)
        begin
            if (n > 1 && $urandom_range(0, 1))
                void'(b.pop_back());
            else
                b.push_back(SYM_W'($urandom));
        end
        else if (sel < 93)
        begin
            target = $urandom_range(0, 2);
            if (target != 1)
                a.delete();
            if (target != 0)
                b.delete();
        end
        else
        begin
            // run one or both strings past the store depth
            target = $urandom_range(0, 2);
            k = DEPTH + 1 + $urandom_range(0, 2);
            if (target != 1)
                while (a.size() < k)
                    a.push_back(SYM_W'($urandom));
            if (target != 0)
                while (b.size() < k)
                    b.push_back(SYM_W'($urandom));
        end
        send_strings(a, b);
    endtask

    // extremes of the symbol values and every outcome but overflow at least once
    task automatic test_directed();
        sym_q_t a;
        sym_q_t b;
        recv_random   = 1'b0;
        sender_bursty = 1'b1;
        // check with nothing loaded, then with one side empty
        send_strings(a, b);
        a = '{8'h41};
        send_strings(a, b);
        a = {};
        b = '{8'h5A};
        send_strings(a, b);
        // rotation built from the extreme symbol values
        a = '{8'h00, 8'hFF};
        b = '{8'hFF, 8'h00};
        send_strings(a, b);
        // equal lengths, no rotation
        a = '{8'h12, 8'h34};
        b = '{8'h12, 8'h35};
        send_strings(a, b);
        // lengths differ
        a = '{8'h01};
        b = '{8'h01, 8'h01};
        send_strings(a, b);
        // ignored kind between loads changes nothing
        send_beat(KIND_FIRST, 8'h07);
        send_beat(KIND_NONE, 8'hFF);
        send_beat(KIND_SECOND, 8'h07);
        send_beat(KIND_NONE, 8'h00);
        send_beat(KIND_CHECK, 8'h00);
        // rotation by two positions
        a = '{8'hAA, 8'h55, 8'hAA};
        b = '{8'hAA, 8'hAA, 8'h55};
        send_strings(a, b);
    endtask

    // full stores, and overflow on either side
    task automatic test_full_stores();
        sym_q_t a;
        sym_q_t b;
        int     k;
        recv_random = 1'b1;
        for (int i = 0; i < DEPTH; i++)
            a.push_back(SYM_W'($urandom));
        k = $urandom_range(1, DEPTH - 1);
        for (int i = 0; i < DEPTH; i++)
            b.push_back(a[(i + k) % DEPTH]);
        send_strings(a, b);
        // one extra symbol on the first, then on the second, then a full first with the second empty
        a.push_back(SYM_W'($urandom));
        send_strings(a, b);
        b.push_back(SYM_W'($urandom));
        void'(a.pop_back());
        send_strings(a, b);
        b.delete();
        send_strings(a, b);
    endtask

    // receiver holds off while checks keep coming
    task automatic test_backpressure();
        recv_random   = 1'b0;
        sender_bursty = 1'b0;
        hold_req      = 1'b1;
        repeat (5) random_case();
    endtask

    // random cases, first with a steady sender and receiver, then with gaps and stalls
    task automatic test_random();
        int stop_at;
        stop_at       = beats_sent + RANDOM_BEATS;
        recv_random   = 1'b0;
        sender_bursty = 1'b0;
        while (beats_sent < stop_at - 3 * RANDOM_BEATS / 4)
            random_case();
        recv_random   = 1'b1;
        sender_bursty = 1'b1;
        while (beats_sent < stop_at)
            random_case();
    endtask

    // receiver ready pattern
    initial
    begin : drive_ready
        int run;
        bit level;
        run   = 0;
        level = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!recv_random)
                out_ch.ready <= rst_n;
            else
            begin
                if (run <= 0)
                begin
                    level = ~level;
                    run = level ? $urandom_range(1, 12) : $urandom_range(1, 8);
                end
                out_ch.ready <= level;
                run--;
            end
        end
    end

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    // compare each result beat with the oldest pending verdict
    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (verdict_q.size() == 0)
                report($sformatf("result beat with nothing pending: is_rotation=%0d status=%0d",
                                 out_ch.is_rotation, out_ch.status));
            else
            begin
                want = verdict_q.pop_front();
                status_seen[want.status]++;
                if (want.is_rotation)
                    rotations_seen++;
                if (out_ch.is_rotation !== want.is_rotation || out_ch.status !== want.status)
                    report($sformatf("expected is_rotation=%0d status=%0d, got %0d / %0d",
                                     want.is_rotation, want.status,
                                     out_ch.is_rotation, out_ch.status));
            end
        end
    end

    // watchdog: cycles in a row with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d cycles without a beat", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // test sequence
    initial
    begin
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.kind   <= KIND_FIRST;
        in_ch.symbol <= '0;
        first_len      = 0;
        second_len     = 0;
        too_long       = 1'b0;
        mismatches     = 0;
        beats_sent     = 0;
        absorbed_beats = 0;
        rotations_seen = 0;
        burst_left     = 0;
        sender_bursty  = 1'b0;
        recv_random    = 1'b0;
        hold_req       = 1'b0;
        idle_cycles    = 0;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_stores();
        test_backpressure();
        test_random();

        in_ch.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $write("checked %0d results: %0d compared (%0d rotations), ",
               status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3],
               status_seen[STATUS_OK], rotations_seen);
        $display("%0d empty, %0d unequal, %0d overflow",
                 status_seen[STATUS_EMPTY], status_seen[STATUS_DIFF],
                 status_seen[STATUS_LONG]);
        $display("sent %0d load/check beats and %0d ignored beats, %0d mismatches",
                 beats_sent, absorbed_beats, mismatches);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
